[hdl/nep_pkg.sv]
// Package: request/result types, pipeline item type, coefficients and fixed-point helpers.
`timescale 1ns / 1ps
package nep_pkg;

    // request and result payloads
    typedef struct packed {
        logic               mode;
        logic signed [31:0] in_a;
        logic signed [31:0] in_b;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic               clamped;
    } res_t;

    // item carried down the pipeline
    typedef struct packed {
        logic               mode;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] yc;
        logic               clamped;
    } item_t;

    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_INV = 1'b1;

    // coefficients in units of 1e-9
    localparam longint NA0 = 870700000;
    localparam longint NA1 = -131979000;
    localparam longint NA2 = -13791000;
    localparam longint NA3 = 3971000;
    localparam longint NA4 = -1529000;
    localparam longint NB0 = 1007226000;
    localparam longint NB1 = 15085000;
    localparam longint NB2 = -44475000;
    localparam longint NB3 = 28874000;
    localparam longint NB4 = -5916000;
    localparam longint NC1 = 3 * NB1;
    localparam longint NC2 = 7 * NB2;
    localparam longint NC3 = 9 * NB3;
    localparam longint NC4 = 11 * NB4;
    localparam longint NMAXY = 1422400056;

    localparam logic signed [63:0] MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] MIN64 = -64'sd2147483648;
    localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;

    // nano-unit constant to fixed point, nearest, ties away from zero
    function automatic logic signed [31:0] kq(input longint nano, input int frac);
        longint one;
        longint r;
        one = longint'(1) <<< frac;
        if (nano >= 0)
            r = (nano * one + 500000000) / 1000000000;
        else
            r = -(((-nano) * one + 500000000) / 1000000000);
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > MAX64)
            r = MAX32;
        else if (v < MIN64)
            r = MIN32;
        else
            r = v[31:0];
        return r;
    endfunction

    // product, rounded to nearest with ties upward, saturated
    function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input int frac);
        logic signed [63:0] p;
        p = a * b;
        p = p + (64'sd1 <<< (frac - 1));
        return sat_q(p >>> frac);
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            r = s[32] ? MIN32 : MAX32;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31])
            r = s[32] ? MIN32 : MAX32;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

[hdl/nep_poly.sv]
// Seven-stage pipeline for the x, y and derivative polynomials in latitude.
`timescale 1ns / 1ps
module nep_poly
    import nep_pkg::*;
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] phi,
    input  item_t              in_item,
    output logic               out_valid,
    output logic signed [31:0] xp,
    output logic signed [31:0] yp,
    output logic signed [31:0] dp,
    output item_t              out_item
);

    localparam logic signed [31:0] KA0 = kq(NA0, FRAC_BITS);
    localparam logic signed [31:0] KA1 = kq(NA1, FRAC_BITS);
    localparam logic signed [31:0] KA2 = kq(NA2, FRAC_BITS);
    localparam logic signed [31:0] KA3 = kq(NA3, FRAC_BITS);
    localparam logic signed [31:0] KA4 = kq(NA4, FRAC_BITS);
    localparam logic signed [31:0] KB0 = kq(NB0, FRAC_BITS);
    localparam logic signed [31:0] KB1 = kq(NB1, FRAC_BITS);
    localparam logic signed [31:0] KB2 = kq(NB2, FRAC_BITS);
    localparam logic signed [31:0] KB3 = kq(NB3, FRAC_BITS);
    localparam logic signed [31:0] KB4 = kq(NB4, FRAC_BITS);
    localparam logic signed [31:0] KC1 = kq(NC1, FRAC_BITS);
    localparam logic signed [31:0] KC2 = kq(NC2, FRAC_BITS);
    localparam logic signed [31:0] KC3 = kq(NC3, FRAC_BITS);
    localparam logic signed [31:0] KC4 = kq(NC4, FRAC_BITS);

    logic [6:0] v_reg;
    item_t      pay1_reg, pay2_reg, pay3_reg, pay4_reg, pay5_reg, pay6_reg, pay7_reg;
    logic signed [31:0] phi1_reg, phi2_reg, phi3_reg, phi4_reg, phi5_reg;
    logic signed [31:0] p2_1_reg, p2_2_reg, p2_3_reg, p2_4_reg, p2_5_reg;
    logic signed [31:0] p4_2_reg, p4_3_reg;
    logic signed [31:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic signed [31:0] y1_reg, y1_3_reg, y2_reg, y3_reg, y4_reg, y5_reg;
    logic signed [31:0] d1_reg, d1_3_reg, d2_reg, d3_reg, d4_reg, dp6_reg;
    logic signed [31:0] xp_reg, yp_reg, dp_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[5:0], in_valid};
    end

    // datapath: at most one multiply deep per stage
    always_ff @(posedge clk)
    begin
        // p2
        pay1_reg <= in_item;
        phi1_reg <= phi;
        p2_1_reg <= mul_q(phi, phi, FRAC_BITS);
        // p4 and first coefficient products
        pay2_reg <= pay1_reg;
        phi2_reg <= phi1_reg;
        p2_2_reg <= p2_1_reg;
        p4_2_reg <= mul_q(p2_1_reg, p2_1_reg, FRAC_BITS);
        x1_reg   <= mul_q(p2_1_reg, KA4, FRAC_BITS);
        y1_reg   <= mul_q(KB3, p2_1_reg, FRAC_BITS);
        d1_reg   <= mul_q(KC3, p2_1_reg, FRAC_BITS);
        // p4 terms
        pay3_reg <= pay2_reg;
        phi3_reg <= phi2_reg;
        p2_3_reg <= p2_2_reg;
        p4_3_reg <= p4_2_reg;
        x2_reg   <= mul_q(add_sat(KA3, x1_reg), p2_2_reg, FRAC_BITS);
        y1_3_reg <= y1_reg;
        d1_3_reg <= d1_reg;
        y2_reg   <= mul_q(KB4, p4_2_reg, FRAC_BITS);
        d2_reg   <= mul_q(KC4, p4_2_reg, FRAC_BITS);
        // inner brackets times p4
        pay4_reg <= pay3_reg;
        phi4_reg <= phi3_reg;
        p2_4_reg <= p2_3_reg;
        x3_reg   <= mul_q(x2_reg, p4_3_reg, FRAC_BITS);
        y3_reg   <= mul_q(p4_3_reg, add_sat(add_sat(KB2, y1_3_reg), y2_reg), FRAC_BITS);
        d3_reg   <= mul_q(p4_3_reg, add_sat(add_sat(KC2, d1_3_reg), d2_reg), FRAC_BITS);
        // times p2
        pay5_reg <= pay4_reg;
        phi5_reg <= phi4_reg;
        p2_5_reg <= p2_4_reg;
        x4_reg   <= mul_q(p2_4_reg, add_sat(KA2, x3_reg), FRAC_BITS);
        y4_reg   <= mul_q(p2_4_reg, add_sat(KB1, y3_reg), FRAC_BITS);
        d4_reg   <= mul_q(p2_4_reg, add_sat(KC1, d3_reg), FRAC_BITS);
        // outer terms
        pay6_reg <= pay5_reg;
        x5_reg   <= mul_q(p2_5_reg, add_sat(KA1, x4_reg), FRAC_BITS);
        y5_reg   <= mul_q(phi5_reg, add_sat(KB0, y4_reg), FRAC_BITS);
        dp6_reg  <= add_sat(KB0, d4_reg);
        // constant term of x
        pay7_reg <= pay6_reg;
        xp_reg   <= add_sat(KA0, x5_reg);
        yp_reg   <= y5_reg;
        dp_reg   <= dp6_reg;
    end

    assign out_valid = v_reg[6];
    assign out_item  = pay7_reg;
    assign xp        = xp_reg;
    assign yp        = yp_reg;
    assign dp        = dp_reg;

endmodule

[hdl/nep_div.sv]
// Pipelined saturating fixed-point divider, one quotient bit per stage.
`timescale 1ns / 1ps
module nep_div
    import nep_pkg::*;
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    input  logic               force_zero,
    input  item_t              in_item,
    output logic               out_valid,
    output logic signed [31:0] quo,
    output item_t              out_item
);

    localparam int QB = 33;
    localparam int DW = 32 + FRAC_BITS;
    localparam int SH = QB - FRAC_BITS;

    logic [31:0]   mag_n, mag_d;
    logic [DW-1:0] d_full;
    logic          ovf_next;

    logic          v_reg    [0:QB];
    item_t         pay_reg  [0:QB];
    logic [32:0]   rem_reg  [0:QB];
    logic [QB-1:0] dlo_reg  [0:QB];
    logic [QB-1:0] q_reg    [0:QB];
    logic [31:0]   dmag_reg [0:QB];
    logic          neg_reg  [0:QB];
    logic          zero_reg [0:QB];
    logic          ovf_reg  [0:QB];

    logic               vo_reg;
    item_t              payo_reg;
    logic signed [31:0] quo_reg;
    logic signed [31:0] quo_next;

    // magnitudes, and quotient overflow beyond 33 bits
    assign mag_n    = num[31] ? (~num + 32'd1) : num;
    assign mag_d    = den[31] ? (~den + 32'd1) : den;
    assign d_full   = {mag_n, {FRAC_BITS{1'b0}}};
    assign ovf_next = {{SH{1'b0}}, mag_n} >= {mag_d, {SH{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pay_reg[0]  <= in_item;
        rem_reg[0]  <= {{(QB + 1 - FRAC_BITS){1'b0}}, d_full[DW-1:QB]};
        dlo_reg[0]  <= d_full[QB-1:0];
        q_reg[0]    <= '0;
        dmag_reg[0] <= mag_d;
        neg_reg[0]  <= num[31] ^ den[31];
        zero_reg[0] <= force_zero || (num == 32'sd0);
        ovf_reg[0]  <= ovf_next;
    end

    // restoring steps
    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        logic [33:0] t;
        logic [33:0] diff;
        logic        ge;
        logic [32:0] rem_next;

        assign t        = {rem_reg[j-1], dlo_reg[j-1][QB-1]};
        assign diff     = t - {2'b00, dmag_reg[j-1]};
        assign ge       = t >= {2'b00, dmag_reg[j-1]};
        assign rem_next = ge ? diff[32:0] : t[32:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else
                v_reg[j] <= v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            pay_reg[j]  <= pay_reg[j-1];
            rem_reg[j]  <= rem_next;
            dlo_reg[j]  <= {dlo_reg[j-1][QB-2:0], 1'b0};
            q_reg[j]    <= {q_reg[j-1][QB-2:0], ge};
            dmag_reg[j] <= dmag_reg[j-1];
            neg_reg[j]  <= neg_reg[j-1];
            zero_reg[j] <= zero_reg[j-1];
            ovf_reg[j]  <= ovf_reg[j-1];
        end
    end

    // sign and saturation
    always_comb
    begin
        if (zero_reg[QB])
            quo_next = '0;
        else if (!neg_reg[QB])
            quo_next = (ovf_reg[QB] || q_reg[QB][32] || q_reg[QB][31]) ?
                       MAX32 : q_reg[QB][31:0];
        else if (ovf_reg[QB] || q_reg[QB][32] || (q_reg[QB][31] && (|q_reg[QB][30:0])))
            quo_next = MIN32;
        else
            quo_next = ~q_reg[QB][31:0] + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else
            vo_reg <= v_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        payo_reg <= pay_reg[QB];
        quo_reg  <= quo_next;
    end

    assign out_valid = vo_reg;
    assign out_item  = payo_reg;
    assign quo       = quo_reg;

endmodule

[hdl/natural_earth_map_projection.sv]
// Top level: Natural Earth forward and inverse projection pipeline.
// A request is taken on every clock cycle in which start is high; busy is always low and
// nothing stalls. Each result appears on res with done high for one cycle, in request
// order. The pipeline is a chain of NEWTON_STEPS + 1 polynomial units of seven stages
// each and NEWTON_STEPS + 1 dividers that resolve one quotient bit per stage.
`timescale 1ns / 1ps
module natural_earth_map_projection
    import nep_pkg::*;
#(
    parameter int NEWTON_STEPS = 6,
    parameter int FRAC_BITS    = 28
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output res_t res
);

    localparam int LAT = 44 * (NEWTON_STEPS + 1);
    localparam logic signed [31:0] MAXY = kq(NMAXY, FRAC_BITS);

    logic  stg_v    [0:NEWTON_STEPS];
    item_t stg_item [0:NEWTON_STEPS];

    logic  in_v_reg;
    item_t in_item_reg;
    item_t in_item_next;

    logic  res_v_reg;
    res_t  res_reg;

    assign busy = 1'b0;

    // clamp y for inverse requests
    always_comb
    begin
        in_item_next.mode    = req.mode;
        in_item_next.a       = req.in_a;
        in_item_next.b       = req.in_b;
        in_item_next.clamped = 1'b0;
        if (req.mode == MODE_INV)
        begin
            if (req.in_b > MAXY)
            begin
                in_item_next.b       = MAXY;
                in_item_next.clamped = 1'b1;
            end
            else if (req.in_b < -MAXY)
            begin
                in_item_next.b       = -MAXY;
                in_item_next.clamped = 1'b1;
            end
        end
        in_item_next.yc = in_item_next.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else
            in_v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    assign stg_v[0]    = in_v_reg;
    assign stg_item[0] = in_item_reg;

    // polynomial unit per iterate, Newton step between them
    for (genvar k = 0; k <= NEWTON_STEPS; k++)
    begin : g_iter
        logic               pv;
        logic signed [31:0] xp, yp, dp;
        item_t              pitem;

        nep_poly #(
            .FRAC_BITS (FRAC_BITS)
        ) u_poly (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_v[k]),
            .phi       (stg_item[k].yc),
            .in_item   (stg_item[k]),
            .out_valid (pv),
            .xp        (xp),
            .yp        (yp),
            .dp        (dp),
            .out_item  (pitem)
        );

        if (k < NEWTON_STEPS)
        begin : g_newton
            logic               f_v_reg;
            item_t              f_item_reg;
            item_t              f_item_next;
            logic signed [31:0] f_reg, dp_reg;
            logic               dz_reg;
            logic               dv;
            logic signed [31:0] st;
            item_t              ditem;
            logic               upd_v_reg;
            item_t              upd_item_reg;
            item_t              upd_item_next;

            // residual; forward results are formed after the first unit
            always_comb
            begin
                f_item_next = pitem;
                if ((k == 0) && (pitem.mode == MODE_FWD))
                begin
                    f_item_next.a  = mul_q(pitem.a, xp, FRAC_BITS);
                    f_item_next.yc = yp;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    f_v_reg <= 1'b0;
                else
                    f_v_reg <= pv;
            end

            always_ff @(posedge clk)
            begin
                f_item_reg <= f_item_next;
                f_reg      <= sub_sat(yp, pitem.b);
                dp_reg     <= dp;
                dz_reg     <= (dp == 32'sd0);
            end

            nep_div #(
                .FRAC_BITS (FRAC_BITS)
            ) u_div (
                .clk        (clk),
                .rst_n      (rst_n),
                .in_valid   (f_v_reg),
                .num        (f_reg),
                .den        (dp_reg),
                .force_zero (dz_reg),
                .in_item    (f_item_reg),
                .out_valid  (dv),
                .quo        (st),
                .out_item   (ditem)
            );

            // latitude update, inverse only
            always_comb
            begin
                upd_item_next = ditem;
                if (ditem.mode == MODE_INV)
                    upd_item_next.yc = sub_sat(ditem.yc, st);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    upd_v_reg <= 1'b0;
                else
                    upd_v_reg <= dv;
            end

            always_ff @(posedge clk)
            begin
                upd_item_reg <= upd_item_next;
            end

            assign stg_v[k+1]    = upd_v_reg;
            assign stg_item[k+1] = upd_item_reg;
        end
        else
        begin : g_final
            logic               qv;
            logic signed [31:0] lon;
            item_t              qitem;

            // longitude = x / x polynomial
            nep_div #(
                .FRAC_BITS (FRAC_BITS)
            ) u_div (
                .clk        (clk),
                .rst_n      (rst_n),
                .in_valid   (pv),
                .num        (pitem.a),
                .den        (xp),
                .force_zero (1'b0),
                .in_item    (pitem),
                .out_valid  (qv),
                .quo        (lon),
                .out_item   (qitem)
            );

            // result register
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    res_v_reg <= 1'b0;
                else
                    res_v_reg <= qv;
            end

            always_ff @(posedge clk)
            begin
                res_reg.out_a   <= (qitem.mode == MODE_INV) ? lon : qitem.a;
                res_reg.out_b   <= qitem.yc;
                res_reg.clamped <= qitem.clamped;
            end
        end
    end

    assign done = res_v_reg;
    assign res  = res_reg;

`ifndef SYNTHESIS
    a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing at fixed latency");

    a_latency_none: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LAT !done)
        else $error("result without request");

    a_clamp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.clamped) |-> $past(start && req.mode, LAT))
        else $error("clamp flag on a request that was not inverse");
`endif

endmodule

[verif/natural_earth_map_projection_test.sv]
// Testbench for the Natural Earth projection pipeline: random and edge-case requests, self-checking.
`timescale 1ns / 1ps
module natural_earth_map_projection_test
    import nep_pkg::*;
();

    localparam int FRAC  = 28;
    localparam int STEPS = 6;
    localparam int LATENCY = 44 * (STEPS + 1);
    localparam int STALL_LIMIT = 4 * LATENCY + 1000;
    localparam int RANDOM_ITEMS = 1700;

    // coefficients, units of 1e-9
    localparam longint XC0 = 870700000, XC1 = -131979000, XC2 = -13791000;
    localparam longint XC3 = 3971000, XC4 = -1529000;
    localparam longint YC0 = 1007226000, YC1 = 15085000, YC2 = -44475000;
    localparam longint YC3 = 28874000, YC4 = -5916000;
    localparam longint Y_LIMIT_NANO = 1422400056;
    localparam logic signed [31:0] PI_Q = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
    // largest y that passes unclamped, in Q4.28
    localparam logic signed [31:0] Y_LIMIT_Q = 32'sd381822608;

    // projection arithmetic on 64-bit integers, saturating to 32 bits
    class projection_scoreboard;
        res_t expected_q[$];
        int   mismatches;

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint fix_const(longint nano);
            longint one;
            one = longint'(1) <<< FRAC;
            if (nano >= 0) return (nano * one + 500000000) / 1000000000;
            return -(((-nano) * one + 500000000) / 1000000000);
        endfunction

        function longint fmul(longint a, longint b);
            longint x;
            x = a * b + (longint'(1) <<< (FRAC - 1));
            return clip(x >>> FRAC);
        endfunction

        function longint fadd(longint a, longint b);
            return clip(a + b);
        endfunction

        function longint fdiv(longint num, longint den);
            if (den == 0) begin
                if (num > 0) return 64'sd2147483647;
                if (num < 0) return -64'sd2147483648;
                return 0;
            end
            return clip((num * (longint'(1) <<< FRAC)) / den);
        endfunction

        function longint height_poly(longint p, longint p2, longint p4);
            longint t;
            t = fadd(fadd(fix_const(YC2), fmul(fix_const(YC3), p2)), fmul(fix_const(YC4), p4));
            t = fadd(fix_const(YC1), fmul(p4, t));
            t = fadd(fix_const(YC0), fmul(p2, t));
            return fmul(p, t);
        endfunction

        function longint width_poly(longint p2, longint p4);
            longint t;
            t = fadd(fix_const(XC3), fmul(p2, fix_const(XC4)));
            t = fmul(t, p2);
            t = fmul(t, p4);
            t = fadd(fix_const(XC2), t);
            t = fadd(fix_const(XC1), fmul(p2, t));
            return fadd(fix_const(XC0), fmul(p2, t));
        endfunction

        function longint slope_poly(longint p2, longint p4);
            longint t;
            t = fadd(fadd(fix_const(7 * YC2), fmul(fix_const(9 * YC3), p2)),
                     fmul(fix_const(11 * YC4), p4));
            t = fadd(fix_const(3 * YC1), fmul(p4, t));
            return fadd(fix_const(YC0), fmul(p2, t));
        endfunction

        // work out the result of one accepted request
        function void note_request(req_t r);
            longint a, b, p2, p4, lat, f, d, st, ylim;
            res_t e;
            a = longint'(r.in_a);
            b = longint'(r.in_b);
            e.clamped = 1'b0;
            if (r.mode == MODE_FWD) begin
                p2 = fmul(b, b);
                p4 = fmul(p2, p2);
                e.out_a = 32'(fmul(a, width_poly(p2, p4)));
                e.out_b = 32'(height_poly(b, p2, p4));
            end
            else begin
                ylim = fix_const(Y_LIMIT_NANO);
                if (b > ylim) begin
                    b = ylim;
                    e.clamped = 1'b1;
                end
                else if (b < -ylim) begin
                    b = -ylim;
                    e.clamped = 1'b1;
                end
                lat = b;
                for (int i = 0; i < STEPS; i++) begin
                    p2 = fmul(lat, lat);
                    p4 = fmul(p2, p2);
                    f = fadd(height_poly(lat, p2, p4), -b);
                    d = slope_poly(p2, p4);
                    st = (d != 0) ? fdiv(f, d) : 0;
                    lat = fadd(lat, -st);
                end
                p2 = fmul(lat, lat);
                p4 = fmul(p2, p2);
                e.out_a = 32'(fdiv(a, width_poly(p2, p4)));
                e.out_b = 32'(lat);
            end
            expected_q.push_back(e);
        endfunction

        task report(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(res_t got);
            res_t e;
            if (expected_q.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (got.out_a !== e.out_a)
                report($sformatf("out_a %0d, expected %0d", got.out_a, e.out_a));
            if (got.out_b !== e.out_b)
                report($sformatf("out_b %0d, expected %0d", got.out_b, e.out_b));
            if (got.clamped !== e.clamped)
                report($sformatf("clamped %0b, expected %0b", got.clamped, e.clamped));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    res_t res;
    projection_scoreboard sb;
    int   idle_cycles = 0;
    bit   idling_on;

    natural_earth_map_projection dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result check and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(res);
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("natural_earth_map_projection verification failed");
                $finish;
            end
        end
    end

    // present one request and hold it until taken
    task send_request(logic m, logic signed [31:0] a, logic signed [31:0] b);
        req_t r;
        r.mode = m;
        r.in_a = a;
        r.in_b = b;
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        sb.note_request(r);
        // random gap after the request
        if (idling_on && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            start <= 1'b0;
            req   <= req_t'({1'($urandom), $urandom, $urandom});
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
    endtask

    task random_request();
        logic m;
        logic signed [31:0] a, b, ylim;
        m = 1'($urandom_range(0, 1));
        ylim = Y_LIMIT_Q;
        case ($urandom_range(0, 9))
            0, 1: begin
                a = $urandom;
                b = $urandom;
            end
            default: begin
                if (m == MODE_FWD) begin
                    a = $signed($urandom_range(0, 2 * PI_Q)) - PI_Q;
                    b = $signed($urandom_range(0, 2 * HALF_PI_Q)) - HALF_PI_Q;
                end
                else begin
                    a = $signed($urandom_range(0, 2 * 32'sd734256000)) - 32'sd734256000;
                    b = $signed($urandom_range(0, 3 * ylim)) - (3 * ylim) / 2;
                end
            end
        endcase
        send_request(m, a, b);
    endtask

    initial
    begin
        sb = new();
        idling_on = 1'b0;
        start = 1'b0;
        req   = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // edge cases: zero, field extremes, the poles, clamp boundary
        send_request(MODE_FWD, 32'sd0, 32'sd0);
        send_request(MODE_FWD, MAX32, MAX32);
        send_request(MODE_FWD, MIN32, MIN32);
        send_request(MODE_FWD, PI_Q, HALF_PI_Q);
        send_request(MODE_FWD, -PI_Q, -HALF_PI_Q);
        send_request(MODE_FWD, MAX32, MIN32);
        send_request(MODE_INV, 32'sd0, 32'sd0);
        send_request(MODE_INV, MAX32, MAX32);
        send_request(MODE_INV, MIN32, MIN32);
        send_request(MODE_INV, 32'sd100, Y_LIMIT_Q);
        send_request(MODE_INV, -32'sd100, -Y_LIMIT_Q);
        send_request(MODE_INV, 32'sd734256000, Y_LIMIT_Q + 32'sd1);
        send_request(MODE_INV, -32'sd734256000, -Y_LIMIT_Q - 32'sd1);
        send_request(MODE_INV, MIN32, 32'sd0);
        send_request(MODE_INV, MAX32, 32'sd200000000);
        send_request(MODE_INV, 32'sd0, MAX32);

        // random part, with a full drain half way and no gaps at the end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idling_on = (i < RANDOM_ITEMS - 300) && ($urandom_range(0, 7) != 0);
            if (i == RANDOM_ITEMS / 2) begin
                @(negedge clk);
                start <= 1'b0;
                while (sb.expected_q.size() != 0) @(posedge clk);
            end
            random_request();
        end
        @(negedge clk);
        start <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("natural_earth_map_projection verification clean");
        else
            $display("natural_earth_map_projection verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/nep_pkg.sv
hdl/nep_poly.sv
hdl/nep_div.sv
hdl/natural_earth_map_projection.sv
verif/natural_earth_map_projection_test.sv
